// ----- sv/cfar_pkg.sv -----
// shared types, constants and the detector function of the cfar block
package cfar_pkg;

	localparam int unsigned MAX_LINE   = 64;
	localparam int unsigned IDX_W      = $clog2(MAX_LINE);
	localparam int unsigned LEN_W      = $clog2(MAX_LINE + 1);

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned DET_W      = 2 * SAMPLE_W - 1;
	localparam int unsigned REF_W      = 6;
	localparam int unsigned GUARD_W    = 5;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned SCALE_W    = 24;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// window sums: up to 63 squared magnitudes of at most 2^30
	localparam int unsigned SUM_W      = DET_W + REF_W - 1;
	localparam int unsigned COMB_W     = SUM_W + 1;
	localparam int unsigned THR_SHIFT  = 17;
	localparam int unsigned LO_W       = 19;
	localparam int unsigned HI_W       = COMB_W - LO_W;
	localparam int unsigned PL_W       = SCALE_W + LO_W;
	localparam int unsigned PH_W       = SCALE_W + HI_W;
	localparam int unsigned THR_W      = 43;
	localparam int unsigned THR_RAW_W  = THR_W + 1;

	// sample rings held by every cell
	localparam int unsigned NUM_RINGS  = 5;
	localparam int unsigned RING_LA    = 0;
	localparam int unsigned RING_LS    = 1;
	localparam int unsigned RING_GA    = 2;
	localparam int unsigned RING_GS    = 3;
	localparam int unsigned RING_CUT   = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DETECTOR_LAW    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_CELLS = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_GUARD_CELLS     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16       = CFG_IDX_W'(4);

	localparam logic [MODE_W-1:0] MODE_CA   = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_SOCA = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_GOCA = MODE_W'(2);

	localparam logic LAW_SQUARE = 1'b1;

	localparam logic [MODE_W-1:0]  WINDOW_MODE_RST = MODE_CA;
	localparam logic               DETECTOR_LAW_RST = LAW_SQUARE;
	localparam logic [REF_W-1:0]   REFERENCE_RST   = REF_W'(8);
	localparam logic [GUARD_W-1:0] GUARD_RST       = GUARD_W'(4);
	localparam logic [SCALE_W-1:0] SCALE_RST       = SCALE_W'(8192);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [NUM_RINGS-1:0][SAMPLE_W-1:0] ring_word_t;
	typedef logic [DET_W-1:0] det_t;
	typedef logic [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic                 load_we;
		logic [IDX_W-1:0]     load_idx;
		logic [NUM_RINGS-1:0] rot;
		logic                 acc_clear;
		logic                 acc_init;
		logic                 acc_run;
		logic                 issue;
		logic                 issue_last;
		logic [LEN_W-1:0]     line_len;
	} cfar_ctl_t;

	// magnitude or square of a signed sample
	function automatic det_t detect(input logic law, input sample_t raw);
		sample_t                mag;
		logic [2*SAMPLE_W-1:0]  sq;
		mag = raw[SAMPLE_W-1] ? (~raw + sample_t'(1)) : raw;
		sq  = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
		return (law == LAW_SQUARE) ? sq[DET_W-1:0] : DET_W'(mag);
	endfunction

endpackage

// ----- sv/cfar_if.sv -----
// valid/ready channel interfaces for samples in and results out
interface cfar_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [cfar_pkg::SAMPLE_W-1:0] sample;
	logic                                line_end;

	modport source (output valid, output sample, output line_end, input ready);
	modport sink (input valid, input sample, input line_end, output ready);
endinterface

interface cfar_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [cfar_pkg::SAMPLE_W-1:0] detection_value;
	logic [cfar_pkg::THR_W-1:0]           threshold_value;
	logic                                result_last;

	modport source (output valid, output detection_value, output threshold_value,
		output result_last, input ready);
	modport sink (input valid, input detection_value, input threshold_value,
		input result_last, output ready);
endinterface

// ----- sv/cfar_cell.sv -----
// one position of the five rotating sample rings
module cfar_cell import cfar_pkg::*; (
	input  logic                 clk,
	input  logic                 load,
	input  sample_t              load_data,
	input  logic [NUM_RINGS-1:0] rot,
	input  logic                 wrap,
	input  ring_word_t           nb,
	input  ring_word_t           head,
	output ring_word_t           q
);

	ring_word_t word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int r = 0; r < NUM_RINGS; r++) begin
				word_q[r] <= load_data;
			end
		end else begin
			for (int r = 0; r < NUM_RINGS; r++) begin
				// last cell of the line closes the ring back to cell zero
				if (rot[r]) begin
					word_q[r] <= wrap ? head[r] : nb[r];
				end
			end
		end
	end

	assign q = word_q;

endmodule

// ----- sv/cfar_ctrl.sv -----
// line load counter and the sequencer that positions, primes and steps the rings
module cfar_ctrl import cfar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_line_end,
	output logic               in_ready,
	input  logic [REF_W-1:0]   refs,
	input  logic [GUARD_W-1:0] guard,
	input  logic               adv,
	output cfar_ctl_t          ctl
);

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_MOD  = 5'b00010,
		ST_POS  = 5'b00100,
		ST_INIT = 5'b01000,
		ST_RUN  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] load_cnt_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] t_q;
	logic [LEN_W-1:0] lrot_q;
	logic [LEN_W-1:0] cnt_q;

	logic             in_xfer;
	logic             room;
	logic [LEN_W-1:0] r_ext;
	logic [LEN_W-1:0] g1_ext;
	logic             rot_l;
	logic             rot_g;
	logic             priming;
	logic             stepping;
	logic             at_last;

	assign in_ready = (state_q == ST_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign room     = (load_cnt_q < LEN_W'(MAX_LINE));
	assign r_ext    = LEN_W'(refs);
	assign g1_ext   = LEN_W'(guard) + LEN_W'(1);
	assign rot_l    = (state_q == ST_POS) && (cnt_q < lrot_q);
	assign rot_g    = (state_q == ST_POS) && (cnt_q < g1_ext);
	assign priming  = (state_q == ST_INIT) && (cnt_q != r_ext);
	assign stepping = (state_q == ST_RUN) && adv;
	assign at_last  = (cnt_q == (len_q - LEN_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			len_q      <= '0;
			t_q        <= '0;
			lrot_q     <= '0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (in_line_end) begin
							len_q      <= room ? (load_cnt_q + LEN_W'(1)) : load_cnt_q;
							load_cnt_q <= '0;
							t_q        <= LEN_W'(guard) + LEN_W'(refs);
							state_q    <= ST_MOD;
						end else if (room) begin
							load_cnt_q <= load_cnt_q + LEN_W'(1);
						end
					end
				end
				// reduce guard plus reference count modulo the line length
				ST_MOD: begin
					if (t_q >= len_q) begin
						t_q <= t_q - len_q;
					end else begin
						lrot_q  <= (t_q == '0) ? '0 : (len_q - t_q);
						cnt_q   <= '0;
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					if (!rot_l && !rot_g) begin
						cnt_q   <= '0;
						state_q <= ST_INIT;
					end else begin
						cnt_q <= cnt_q + LEN_W'(1);
					end
				end
				ST_INIT: begin
					if (cnt_q == r_ext) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end else begin
						cnt_q <= cnt_q + LEN_W'(1);
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (at_last) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							cnt_q <= cnt_q + LEN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		ctl               = '0;
		ctl.load_we       = in_xfer && room;
		ctl.load_idx      = load_cnt_q[IDX_W-1:0];
		ctl.rot[RING_LA]  = rot_l || priming || stepping;
		ctl.rot[RING_LS]  = rot_l || stepping;
		ctl.rot[RING_GA]  = rot_g || priming || stepping;
		ctl.rot[RING_GS]  = rot_g || stepping;
		ctl.rot[RING_CUT] = stepping;
		ctl.acc_clear     = in_xfer && in_line_end;
		ctl.acc_init      = priming;
		ctl.acc_run       = stepping;
		ctl.issue         = stepping;
		ctl.issue_last    = stepping && at_last;
		ctl.line_len      = len_q;
	end

`ifndef ASSERT_OFF
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue && ctl.issue_last |=> state_q == ST_LOAD)
		else $error("run did not end after the last cell");

	a_load_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= LEN_W'(MAX_LINE))
		else $error("load count beyond line capacity");

	a_run_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> len_q != '0 && cnt_q < len_q)
		else $error("cell index outside the line");
`endif

endmodule

// ----- sv/cfar_thresh.sv -----
// window combine, split scale multiply, threshold compare and output register
module cfar_thresh import cfar_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                issue,
	input  logic                issue_last,
	input  sum_t                lead,
	input  sum_t                lag,
	input  sample_t             cut_sample,
	input  logic [MODE_W-1:0]   mode,
	input  logic [SCALE_W-1:0]  scale,
	input  logic                out_ready,
	output logic                adv,
	output logic                out_valid,
	output sample_t             detection,
	output logic [THR_W-1:0]    threshold,
	output logic                last
);

	logic [COMB_W-1:0]    comb;
	logic [THR_RAW_W-1:0] thr_raw;
	logic [THR_W-1:0]     thr_sat;
	logic                 hit;

	logic                 vld_s1, vld_s2, vld_s3;
	logic [COMB_W-1:0]    v_s1;
	sample_t              smp_s1, smp_s2, smp_s3;
	logic                 last_s1, last_s2, last_s3;
	logic [PL_W-1:0]      pl_s2;
	logic [PH_W-1:0]      ph_s2;
	logic [THR_RAW_W-1:0] thr_s3;

	logic                 out_valid_q;
	sample_t              det_q;
	logic [THR_W-1:0]     thr_q;
	logic                 last_q;

	assign adv = !out_valid_q || out_ready;

	// min and max are doubled so that every mode shares one shift
	always_comb begin
		case (mode)
			MODE_SOCA: comb = (lead < lag) ? {1'b0, lead} << 1 : {1'b0, lag} << 1;
			MODE_GOCA: comb = (lead > lag) ? {1'b0, lead} << 1 : {1'b0, lag} << 1;
			MODE_CA:   comb = COMB_W'(lead) + COMB_W'(lag);
			default:   comb = COMB_W'(lead) + COMB_W'(lag);
		endcase
	end

	// high partial product has its low bits clear, so it is shifted alone
	assign thr_raw = (THR_RAW_W'(ph_s2) << (LO_W - THR_SHIFT))
		+ THR_RAW_W'(pl_s2 >> THR_SHIFT);

	assign thr_sat = thr_s3[THR_W] ? {THR_W{1'b1}} : thr_s3[THR_W-1:0];
	assign hit = !smp_s3[SAMPLE_W-1]
		&& ({{(THR_W-SAMPLE_W+1){1'b0}}, smp_s3[SAMPLE_W-2:0]} > thr_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= issue;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1    <= comb;
			smp_s1  <= cut_sample;
			last_s1 <= issue_last;

			pl_s2   <= PL_W'(scale) * PL_W'(v_s1[LO_W-1:0]);
			ph_s2   <= PH_W'(scale) * PH_W'(v_s1[COMB_W-1:LO_W]);
			smp_s2  <= smp_s1;
			last_s2 <= last_s1;

			thr_s3  <= thr_raw;
			smp_s3  <= smp_s2;
			last_s3 <= last_s2;

			det_q   <= hit ? smp_s3 : '0;
			thr_q   <= thr_sat;
			last_q  <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign detection = det_q;
	assign threshold = thr_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	a_detection_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && det_q != '0 |-> !det_q[SAMPLE_W-1])
		else $error("negative sample passed as a detection");
`endif

endmodule

// ----- sv/ca_so_go_cfar_detector.sv -----
// Line CFAR detector (cell averaging, smallest-of, greatest-of) over a circular line.
// Samples of a line are taken one per cycle, up to 64; the sample marked as line end
// closes the line, and a line of len samples then gives len results in order. After
// the line end the block takes no sample until the run ends. The modulo loop reduces
// G+R (guard plus reference counts) modulo len; the ring positioning then turns the
// leading rings by d = (len - (G+R) mod len) mod len and the lagging rings by G+1,
// and the window priming adds R samples; both advance one ring position per cycle, and
// the run then yields one cell per cycle while the output side takes it; a stalled
// output holds the run. Results pass combine, multiply, compare and output registers.
// Every cell of the row keeps five copies of its sample, one per rotating ring
// (leading add and drop, lagging add and drop, cell under test), so the sliding
// window sums need only fixed taps at cell zero. Threshold is
// (scale * combined sum) >> 16, with the cell-averaging sum halved, saturated to
// 43 bits. Store contents are undefined after reset; only the current line is read.
module ca_so_go_cfar_detector import cfar_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	cfar_in_if.sink               sample_ch,
	cfar_out_if.source            result_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [MODE_W-1:0]  window_mode_q;
	logic               detector_law_q;
	logic [REF_W-1:0]   reference_cells_q;
	logic [GUARD_W-1:0] guard_cells_q;
	logic [SCALE_W-1:0] scale_q;

	cfar_ctl_t          ctl;
	logic               adv;
	logic [IDX_W-1:0]   last_idx;
	logic [MAX_LINE-1:0] cell_load;
	logic [MAX_LINE-1:0] cell_wrap;
	ring_word_t         cell_q [MAX_LINE];

	det_t               d_la, d_ls, d_ga, d_gs;
	sum_t               lead_q, lag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_mode_q     <= WINDOW_MODE_RST;
			detector_law_q    <= DETECTOR_LAW_RST;
			reference_cells_q <= REFERENCE_RST;
			guard_cells_q     <= GUARD_RST;
			scale_q           <= SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WINDOW_MODE:     window_mode_q     <= cfg_wdata[MODE_W-1:0];
				CFG_DETECTOR_LAW:    detector_law_q    <= cfg_wdata[0];
				CFG_REFERENCE_CELLS: reference_cells_q <= cfg_wdata[REF_W-1:0];
				CFG_GUARD_CELLS:     guard_cells_q     <= cfg_wdata[GUARD_W-1:0];
				CFG_SCALE_Q16:       scale_q           <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	cfar_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sample_ch.valid),
		.in_line_end (sample_ch.line_end),
		.in_ready    (sample_ch.ready),
		.refs        (reference_cells_q),
		.guard       (guard_cells_q),
		.adv         (adv),
		.ctl         (ctl)
	);

	assign last_idx = IDX_W'(ctl.line_len - LEN_W'(1));

	for (genvar k = 0; k < MAX_LINE; k++) begin : g_cell
		localparam int unsigned NXT = (k == MAX_LINE - 1) ? 0 : k + 1;

		assign cell_load[k] = ctl.load_we && (ctl.load_idx == IDX_W'(k));
		assign cell_wrap[k] = (last_idx == IDX_W'(k));

		cfar_cell u_cell (
			.clk       (clk),
			.load      (cell_load[k]),
			.load_data (sample_ch.sample),
			.rot       (ctl.rot),
			.wrap      (cell_wrap[k]),
			.nb        (cell_q[NXT]),
			.head      (cell_q[0]),
			.q         (cell_q[k])
		);
	end

	// ring heads sit at cell zero
	assign d_la = detect(detector_law_q, cell_q[0][RING_LA]);
	assign d_ls = detect(detector_law_q, cell_q[0][RING_LS]);
	assign d_ga = detect(detector_law_q, cell_q[0][RING_GA]);
	assign d_gs = detect(detector_law_q, cell_q[0][RING_GS]);

	always_ff @(posedge clk) begin
		if (ctl.acc_clear) begin
			lead_q <= '0;
			lag_q  <= '0;
		end else if (ctl.acc_init) begin
			lead_q <= lead_q + SUM_W'(d_la);
			lag_q  <= lag_q + SUM_W'(d_ga);
		end else if (ctl.acc_run) begin
			lead_q <= lead_q + SUM_W'(d_la) - SUM_W'(d_ls);
			lag_q  <= lag_q + SUM_W'(d_ga) - SUM_W'(d_gs);
		end
	end

	cfar_thresh u_thresh (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (ctl.issue),
		.issue_last (ctl.issue_last),
		.lead       (lead_q),
		.lag        (lag_q),
		.cut_sample (cell_q[0][RING_CUT]),
		.mode       (window_mode_q),
		.scale      (scale_q),
		.out_ready  (result_ch.ready),
		.adv        (adv),
		.out_valid  (result_ch.valid),
		.detection  (result_ch.detection_value),
		.threshold  (result_ch.threshold_value),
		.last       (result_ch.result_last)
	);

endmodule
